[design/quantized_prelu_per_channel_defines.svh]
// Assertion helpers for the PReLU block
`ifndef QUANTIZED_PRELU_PER_CHANNEL_DEFINES_SVH
`define QUANTIZED_PRELU_PER_CHANNEL_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define QPRELU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during rst
`define QPRELU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/qprelu_pkg.sv]
package qprelu_pkg;

  localparam int DEFAULT_MAX_CHANNELS = 256;

  localparam int SAMPLE_W   = 8;
  localparam int CHANNEL_W  = 8;
  localparam int FRAC_W     = 17;
  localparam int COUNT_W    = 9;
  localparam int CSR_IDX_W  = 2;
  localparam int CSR_DATA_W = 9;

  localparam logic [FRAC_W-1:0] ALPHA_ONE = FRAC_W'(65536);
  localparam int ROUND_HALF = 32'h0000_8000;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PROCESS = 1'b1;

  localparam logic [CSR_IDX_W-1:0] REG_ZERO_POINT    = CSR_IDX_W'(0);
  localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT = CSR_IDX_W'(1);

endpackage

[design/qprelu_req_if.sv]
interface qprelu_req_if import qprelu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [SAMPLE_W-1:0]  sample;
  logic                 start_of_tensor;
  logic [CHANNEL_W-1:0] alpha_index;
  logic [FRAC_W-1:0]    alpha_fraction;

  modport source (
    output valid, command, sample, start_of_tensor, alpha_index, alpha_fraction,
    input  ready
  );
  modport sink (
    input  valid, command, sample, start_of_tensor, alpha_index, alpha_fraction,
    output ready
  );
endinterface

[design/qprelu_rsp_if.sv]
interface qprelu_rsp_if import qprelu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SAMPLE_W-1:0]  result;
  logic [CHANNEL_W-1:0] channel;

  modport source (
    output valid, result, channel,
    input  ready
  );
  modport sink (
    input  valid, result, channel,
    output ready
  );
endinterface

[design/qprelu_csr_if.sv]
interface qprelu_csr_if import qprelu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CSR_IDX_W-1:0]  index;
  logic [CSR_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

[design/quantized_prelu_per_channel.sv]
// Stages: table read, scale, output register. Throughput: one transaction per
// cycle unless response.ready stalls the pipe; the alpha table's single read
// port serves one sample per cycle and a load writes it in the accept cycle.
// Reset (rst, synchronous): clears pipeline valids and channel counter,
// zero_point to 0, channel_count to 1. The alpha table keeps its contents.
`include "quantized_prelu_per_channel_defines.svh"

module quantized_prelu_per_channel import qprelu_pkg::*; #(
  parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS
) (
  input  logic         clk,
  input  logic         rst,
  qprelu_csr_if.sink   csr,
  qprelu_req_if.sink   request,
  qprelu_rsp_if.source response
);

  localparam int AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int IW    = (AW > CHANNEL_W) ? AW : CHANNEL_W;
  localparam int LIMIT = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;
  localparam int PW    = SAMPLE_W + FRAC_W;

  logic [FRAC_W-1:0] alpha_mem [MAX_CHANNELS];

  logic [SAMPLE_W-1:0]  zero_point;
  logic [COUNT_W-1:0]   channel_count;
  logic [CHANNEL_W-1:0] counter;
  logic [CHANNEL_W-1:0] counter_next;

  logic en1, en2, en3;
  logic accept, accept_proc, accept_load;

  logic [COUNT_W-1:0]   n_eff;
  logic [CHANNEL_W-1:0] ch_sel, ch_pick;
  logic [IW-1:0]        ch_ext, idx_ext;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [FRAC_W-1:0]    frac_sat;
  logic                 idx_ok;

  logic                 v1;
  logic [SAMPLE_W-1:0]  s1_sample;
  logic [CHANNEL_W-1:0] s1_ch;
  logic                 s1_below;
  logic [FRAC_W-1:0]    rd_alpha;

  logic [PW-1:0]        prod_s, prod_z;

  logic                 v2;
  logic [SAMPLE_W-1:0]  s2_sample;
  logic [CHANNEL_W-1:0] s2_ch;
  logic                 s2_below;
  logic [SAMPLE_W-1:0]  s2_scaled, s2_zscaled;

  logic                 o_valid;
  logic [SAMPLE_W-1:0]  o_result;
  logic [CHANNEL_W-1:0] o_channel;

  // configuration
  assign csr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_point    <= '0;
      channel_count <= COUNT_W'(1);
    end else if (csr.valid) begin
      unique case (csr.index)
        REG_ZERO_POINT:    zero_point    <= csr.data[SAMPLE_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= csr.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  assign en3 = !o_valid || response.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign request.ready = en1;
  assign accept        = request.valid && en1;
  assign accept_proc   = accept && (request.command == CMD_PROCESS);
  assign accept_load   = accept && (request.command == CMD_LOAD);

  // channel selection
  always_comb begin
    if (channel_count == '0) begin
      n_eff = COUNT_W'(1);
    end else if (channel_count > COUNT_W'(LIMIT)) begin
      n_eff = COUNT_W'(LIMIT);
    end else begin
      n_eff = channel_count;
    end
    ch_sel  = request.start_of_tensor ? '0 : counter;
    ch_pick = ({1'b0, ch_sel} >= n_eff) ? '0 : ch_sel;
    if (({1'b0, ch_pick} + COUNT_W'(1)) >= n_eff) begin
      counter_next = '0;
    end else begin
      counter_next = ch_pick + CHANNEL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (accept_proc) begin
      counter <= counter_next;
    end
  end

  // alpha table
  assign ch_ext   = IW'(ch_pick);
  assign idx_ext  = IW'(request.alpha_index);
  assign rd_addr  = ch_ext[AW-1:0];
  assign wr_addr  = idx_ext[AW-1:0];
  assign idx_ok   = (32'(request.alpha_index) < MAX_CHANNELS);
  assign frac_sat = (request.alpha_fraction > ALPHA_ONE) ? ALPHA_ONE
                                                         : request.alpha_fraction;

  always_ff @(posedge clk) begin
    if (accept_load && idx_ok) begin
      alpha_mem[wr_addr] <= frac_sat;
    end
    if (en1) begin
      rd_alpha <= alpha_mem[rd_addr];
    end
  end

  // stage 1: table read
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= accept_proc;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sample <= request.sample;
      s1_ch     <= ch_pick;
      s1_below  <= (request.sample < zero_point);
    end
  end

  // stage 2: scale sample and zero point
  assign prod_s = PW'(s1_sample) * PW'(rd_alpha) + PW'(ROUND_HALF);
  assign prod_z = PW'(zero_point) * PW'(rd_alpha) + PW'(ROUND_HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_sample  <= s1_sample;
      s2_ch      <= s1_ch;
      s2_below   <= s1_below;
      s2_scaled  <= prod_s[23:16];
      s2_zscaled <= prod_z[23:16];
    end
  end

  // stage 3: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en3) begin
      o_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      o_result  <= s2_below ? (s2_scaled + zero_point - s2_zscaled) : s2_sample;
      o_channel <= s2_ch;
    end
  end

  assign response.valid   = o_valid;
  assign response.result  = o_result;
  assign response.channel = o_channel;

  `QPRELU_ASSERT_NEXT(a_proc_enters_pipe, accept_proc, v1, "process transaction lost")
  `QPRELU_ASSERT_NEXT(a_load_keeps_counter, accept_load, $stable(counter), "load moved counter")
  `QPRELU_ASSERT_NOW(a_counter_in_range, 1'b1, COUNT_W'(counter) < COUNT_W'(LIMIT), "counter range")
  `QPRELU_ASSERT_NEXT(a_stall_holds_s2, v2 && !en2, v2 && $stable(s2_ch), "stage 2 stall")

endmodule

[sim/prelu_checker.sv]
`timescale 1ns / 100ps

module prelu_checker import qprelu_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  qprelu_csr_if        csr,
  qprelu_req_if        request,
  qprelu_rsp_if        response,
  output int           mismatches,
  output int           outstanding
);

  typedef struct packed {
    logic [SAMPLE_W-1:0]  result;
    logic [CHANNEL_W-1:0] channel;
  } prelu_out_t;

  logic [FRAC_W-1:0]    slope [DEFAULT_MAX_CHANNELS];
  logic [SAMPLE_W-1:0]  zero_pt;
  logic [COUNT_W-1:0]   chan_count;
  logic [CHANNEL_W-1:0] next_channel;
  prelu_out_t           owed_outputs [$];
  prelu_out_t           want;
  prelu_out_t           got;
  int                   fail_count = 0;

  assign mismatches = fail_count;

  function automatic prelu_out_t apply_prelu(input logic [SAMPLE_W-1:0] s, input logic sot);
    int unsigned n;
    int unsigned ch;
    int unsigned scaled;
    int unsigned zscaled;
    prelu_out_t  o;
    n = (chan_count == 0) ? 1 : chan_count;
    if (n > DEFAULT_MAX_CHANNELS) n = DEFAULT_MAX_CHANNELS;
    if (n > 256) n = 256;
    ch = sot ? 0 : next_channel;
    if (ch >= n) ch = 0;
    next_channel = (ch + 1 >= n) ? '0 : CHANNEL_W'(ch + 1);
    o.result  = s;
    o.channel = CHANNEL_W'(ch);
    if (s < zero_pt) begin
      scaled   = (32'(s) * 32'(slope[ch]) + 32'(ROUND_HALF)) >> 16;
      zscaled  = (32'(zero_pt) * 32'(slope[ch]) + 32'(ROUND_HALF)) >> 16;
      o.result = SAMPLE_W'(scaled + 32'(zero_pt) - zscaled);
    end
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      zero_pt      = '0;
      chan_count   = COUNT_W'(1);
      next_channel = '0;
      owed_outputs.delete();
    end else begin
      if (csr.valid && csr.ready) begin
        case (csr.index)
          REG_ZERO_POINT:    zero_pt = csr.data[SAMPLE_W-1:0];
          REG_CHANNEL_COUNT: chan_count = csr.data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (request.valid && request.ready) begin
        if (request.command == CMD_LOAD) begin
          slope[request.alpha_index] =
            (request.alpha_fraction > ALPHA_ONE) ? ALPHA_ONE : request.alpha_fraction;
        end else begin
          owed_outputs.push_back(apply_prelu(request.sample, request.start_of_tensor));
        end
      end
      if (response.valid && response.ready) begin
        got.result  = response.result;
        got.channel = response.channel;
        if (owed_outputs.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected response transaction, expected none, actual result %0d channel %0d",
                   $time, got.result, got.channel);
        end else begin
          want = owed_outputs.pop_front();
          if (got.result !== want.result) begin
            fail_count++;
            $display("%0t: result mismatch, expected %0d, actual %0d",
                     $time, want.result, got.result);
          end
          if (got.channel !== want.channel) begin
            fail_count++;
            $display("%0t: channel mismatch, expected %0d, actual %0d",
                     $time, want.channel, got.channel);
          end
        end
      end
    end
    outstanding <= owed_outputs.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench import qprelu_pkg::*; ();

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASES       = 9;
  localparam int FIXED_PHASES = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [CSR_IDX_W-1:0] REG_SPARE = CSR_IDX_W'(3);

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  bit   gaps_on = 1'b1;
  bit   rsp_steady = 1'b0;
  int   hold_left = 0;
  int   outstanding;
  int   mismatches;

  int zp_plan    [PHASES] = '{0, 255, 77, 200, 150, 150, 0, 0, 0};
  int count_plan [PHASES] = '{1, 256, 0, 511, 200, 5, 0, 0, 0};
  int items_plan [PHASES] = '{20, 20, 20, 20, 32, 20, 20, 15, 15};
  int sot_plan   [PHASES] = '{10, 10, 10, 10, 0, 10, 10, 10, 10};

  logic [SAMPLE_W-1:0] dir_samples [8] = '{0, 255, 127, 128, 1, 0, 254, 64};
  logic                dir_sot     [8] = '{1, 0, 0, 0, 0, 0, 1, 0};

  qprelu_csr_if csr ();
  qprelu_req_if request ();
  qprelu_rsp_if response ();

  quantized_prelu_per_channel uut (
    .clk      (clk),
    .rst      (rst),
    .csr      (csr),
    .request  (request),
    .response (response)
  );

  prelu_checker check_prelu (
    .clk         (clk),
    .rst         (rst),
    .csr         (csr),
    .request     (request),
    .response    (response),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      response.ready <= 1'b0;
      hold_left <= 0;
    end else if (rsp_steady) begin
      response.ready <= 1'b1;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else begin
      response.ready <= ($urandom_range(99) < 70);
      hold_left <= ($urandom_range(19) == 0) ? $urandom_range(40, 15) : $urandom_range(3);
    end
  end

  function automatic logic [FRAC_W-1:0] pick_slope();
    case ($urandom_range(5))
      0: return '0;
      1: return ALPHA_ONE;
      2: return FRAC_W'($urandom_range(131071, 65537));
      3: return FRAC_W'(1);
      default: return FRAC_W'($urandom_range(65536));
    endcase
  endfunction

  task automatic send_item(input logic cmd, input logic [SAMPLE_W-1:0] s, input logic sot,
                           input logic [CHANNEL_W-1:0] idx, input logic [FRAC_W-1:0] frac);
    int gap;
    if (!gaps_on || $urandom_range(99) < 55) gap = 0;
    else if ($urandom_range(9) != 0) gap = $urandom_range(3, 1);
    else gap = $urandom_range(30, 10);
    if (gap != 0) begin
      request.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request.valid           <= 1'b1;
    request.command         <= cmd;
    request.sample          <= s;
    request.start_of_tensor <= sot;
    request.alpha_index     <= idx;
    request.alpha_fraction  <= frac;
    do @(negedge clk); while (!request.ready);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
    csr.valid <= 1'b1;
    csr.index <= idx;
    csr.data  <= CSR_DATA_W'(value);
    do @(negedge clk); while (!csr.ready);
    @(posedge clk);
    csr.valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender until every response has come back and the pipe is empty
  task automatic settle();
    request.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [SAMPLE_W-1:0] s;
    request.valid           <= 1'b0;
    request.command         <= CMD_LOAD;
    request.sample          <= '0;
    request.start_of_tensor <= 1'b0;
    request.alpha_index     <= '0;
    request.alpha_fraction  <= '0;
    csr.valid               <= 1'b0;
    csr.index               <= '0;
    csr.data                <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DEFAULT_MAX_CHANNELS; i++)
      send_item(CMD_LOAD, SAMPLE_W'($urandom), 1'($urandom_range(1)), CHANNEL_W'(i),
                pick_slope());
    settle();

    write_reg(REG_ZERO_POINT, 128);
    write_reg(REG_CHANNEL_COUNT, 4);
    write_reg(REG_SPARE, 511);
    send_item(CMD_LOAD, 8'd0, 1'b0, 8'd0, FRAC_W'(32768));
    send_item(CMD_LOAD, 8'd255, 1'b1, 8'd1, FRAC_W'(131071));
    send_item(CMD_LOAD, 8'd0, 1'b0, 8'd2, '0);
    send_item(CMD_LOAD, 8'd0, 1'b0, 8'd3, ALPHA_ONE);
    for (int i = 0; i < 8; i++)
      send_item(CMD_PROCESS, dir_samples[i], dir_sot[i], 8'd255, FRAC_W'(131071));
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p >= FIXED_PHASES) begin
        zp_plan[p]    = $urandom_range(255);
        count_plan[p] = $urandom_range(256, 1);
      end
      gaps_on    = ($urandom_range(3) != 0);
      rsp_steady = ($urandom_range(3) == 0);
      write_reg(REG_ZERO_POINT, zp_plan[p]);
      write_reg(REG_CHANNEL_COUNT, count_plan[p]);
      for (int k = 0; k < items_plan[p]; k++) begin
        if ($urandom_range(99) < 15) begin
          send_item(CMD_LOAD, SAMPLE_W'($urandom), 1'($urandom_range(1)),
                    CHANNEL_W'($urandom), pick_slope());
        end else begin
          if (zp_plan[p] != 0 && $urandom_range(1) == 1)
            s = SAMPLE_W'($urandom_range(zp_plan[p] - 1));
          else s = SAMPLE_W'($urandom_range(255));
          send_item(CMD_PROCESS, s, ($urandom_range(99) < sot_plan[p]),
                    CHANNEL_W'($urandom), FRAC_W'($urandom));
        end
      end
      settle();
    end

    rsp_steady = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
